// File: hdl/lfu_key_value_cache_core_assert.svh
// Assertion helpers used by the cache core RTL
`ifndef LFU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LFU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LFUKV_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define LFUKV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/lfukv_pkg.sv
package lfukv_pkg;

   // One slot of the entry memory
   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
      logic [15:0] count;
      logic [31:0] stamp;
   } entry_type;

   // Status of one scan over the entry memory
   typedef struct packed {
      logic match_found;
      logic victim_found;
      logic free_found;
   } scan_flags_type;

   localparam logic        OP_GET = 1'b0;
   localparam logic        OP_PUT = 1'b1;

   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [15:0] COUNT_ONE  = 16'd1;
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Register file: one register, selected by address bit 2
   localparam int          CSR_ADDR_W            = 3;
   localparam logic        CSR_IDX_LIVE_CAPACITY = 1'b0;
   localparam logic [3:0]  LIVE_CAPACITY_RESET   = 4'd8;

endpackage

// File: hdl/lfukv_scan.sv
module lfukv_scan #(
   parameter int IDX_W = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      probe_en,
   input  logic [IDX_W-1:0]          probe_slot,
   input  logic                      probe_valid,
   input  lfukv_pkg::entry_type      probe_entry,
   input  logic [31:0]               lookup_key,
   input  logic [31:0]               access_clock,
   output lfukv_pkg::scan_flags_type flags,
   output logic [IDX_W-1:0]          match_slot,
   output lfukv_pkg::entry_type      match_entry,
   output logic [IDX_W-1:0]          victim_slot,
   output logic [IDX_W-1:0]          free_slot
);

   lfukv_pkg::scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]          match_slot_ff, match_slot_in;
   lfukv_pkg::entry_type      match_entry_ff, match_entry_in;
   logic [IDX_W-1:0]          victim_slot_ff, victim_slot_in;
   logic [IDX_W-1:0]          free_slot_ff, free_slot_in;
   logic [15:0]               best_count_ff, best_count_in;
   logic [31:0]               best_age_ff, best_age_in;

   logic [31:0] age;
   logic        take_match;
   logic        take_victim;
   logic        take_free;

   // Compare the probed slot against the running match, victim and free slot
   always_comb begin
      age        = 32'(access_clock - probe_entry.stamp);
      take_match = probe_en && probe_valid && !flags_ff.match_found &&
                   (probe_entry.key == lookup_key);
      take_victim = probe_en && probe_valid &&
                    (!flags_ff.victim_found ||
                     (probe_entry.count < best_count_ff) ||
                     ((probe_entry.count == best_count_ff) && (age > best_age_ff)));
      take_free  = probe_en && !probe_valid && !flags_ff.free_found;

      flags_in       = flags_ff;
      match_slot_in  = match_slot_ff;
      match_entry_in = match_entry_ff;
      victim_slot_in = victim_slot_ff;
      free_slot_in   = free_slot_ff;
      best_count_in  = best_count_ff;
      best_age_in    = best_age_ff;

      if (clear) begin
         flags_in = '0;
      end else begin
         if (take_match) begin
            flags_in.match_found = 1'b1;
            match_slot_in        = probe_slot;
            match_entry_in       = probe_entry;
         end
         if (take_victim) begin
            flags_in.victim_found = 1'b1;
            victim_slot_in        = probe_slot;
            best_count_in         = probe_entry.count;
            best_age_in           = age;
         end
         if (take_free) begin
            flags_in.free_found = 1'b1;
            free_slot_in        = probe_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      match_slot_ff  <= match_slot_in;
      match_entry_ff <= match_entry_in;
      victim_slot_ff <= victim_slot_in;
      free_slot_ff   <= free_slot_in;
      best_count_ff  <= best_count_in;
      best_age_ff    <= best_age_in;
   end

   assign flags       = flags_ff;
   assign match_slot  = match_slot_ff;
   assign match_entry = match_entry_ff;
   assign victim_slot = victim_slot_ff;
   assign free_slot   = free_slot_ff;

endmodule

// File: hdl/lfu_key_value_cache_core.sv
// Channel  | Direction | Signals                                   | Word
// ---------+-----------+-------------------------------------------+---------------------------
// req      | in        | req_tvalid/tready, tdata[63:0], tuser[0]  | op, key, store value
// rsp      | out       | rsp_tvalid/tready, tdata[31:0], tuser[0]  | hit, read value
// csr      | in/out    | psel, penable, pwrite, paddr, pwdata...   | live_capacity at 0x0
//
// Each request is accepted, then sweeps every slot through the entry memory's single
// registered read port (one slot a cycle), and then writes back the touched or
// inserted slot, if any.
// Reset is synchronous, active high; it clears all valid bits, occupancy and the
// access clock at once, so no clearing pass is needed.
// A get result waits in the output register; while it is stalled the next request is
// still accepted and scanned, and a get then holds in its write-back cycle until the
// result moves.
`include "lfu_key_value_cache_core_assert.svh"

module lfu_key_value_cache_core #(
   parameter int ENTRIES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request word
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,   // [31:0] lookup_key, [63:32] store_value
   input  logic [0:0]                       req_tuser,   // [0] op
   // response word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [31:0] read_value
   output logic [0:0]                       rsp_tuser,   // [0] hit
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lfukv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);
   localparam logic [7:0]       ENT_CAP  = 8'(ENTRIES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [31:0]          key_ff, key_in;
   logic [31:0]          value_ff, value_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     occupancy_ff, occupancy_in;
   logic [31:0]          access_clock_ff, access_clock_in;
   logic [3:0]           live_capacity_ff, live_capacity_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;

   // entry memory
   lfukv_pkg::entry_type mem [ENTRIES];
   lfukv_pkg::entry_type mem_rdata_ff;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   lfukv_pkg::entry_type mem_wdata;

   // scan results
   logic                      scan_clear;
   lfukv_pkg::scan_flags_type scan_flags;
   logic [IDX_W-1:0]          match_slot;
   lfukv_pkg::entry_type      match_entry;
   logic [IDX_W-1:0]          victim_slot;
   logic [IDX_W-1:0]          free_slot;

   // update decisions
   logic [7:0]       cap_eff;
   logic             need_evict;
   logic [IDX_W-1:0] ins_slot;
   logic [15:0]      bumped_count;
   logic             req_fire;
   logic             csr_write;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign mem_raddr  = rd_cnt_ff[IDX_W-1:0];

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == lfukv_pkg::CSR_IDX_LIVE_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == lfukv_pkg::CSR_IDX_LIVE_CAPACITY) ?
                       {28'd0, live_capacity_ff} : 32'd0;
   assign live_capacity_in = csr_write ? csr_pwdata[3:0] : live_capacity_ff;

   // Track match, victim and first free slot over the sweep
   lfukv_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .clear        (scan_clear),
      .probe_en     (rd_pend_ff),
      .probe_slot   (rd_slot_ff),
      .probe_valid  (valid_ff[rd_slot_ff]),
      .probe_entry  (mem_rdata_ff),
      .lookup_key   (key_ff),
      .access_clock (access_clock_ff),
      .flags        (scan_flags),
      .match_slot   (match_slot),
      .match_entry  (match_entry),
      .victim_slot  (victim_slot),
      .free_slot    (free_slot)
   );

   // Capacity clamp, eviction need, insert slot and saturating use count
   always_comb begin
      cap_eff    = ({4'd0, live_capacity_ff} > ENT_CAP) ? ENT_CAP : {4'd0, live_capacity_ff};
      need_evict = (8'(occupancy_ff) >= cap_eff);
      ins_slot   = (need_evict && (!scan_flags.free_found || (victim_slot < free_slot))) ?
                   victim_slot : free_slot;
      bumped_count = (match_entry.count == lfukv_pkg::COUNT_MAX) ?
                     match_entry.count : 16'(match_entry.count + 16'd1);
   end

   // Sequencer: accept, sweep, write back
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      rd_cnt_in       = rd_cnt_ff;
      rd_pend_in      = 1'b0;
      rd_slot_in      = rd_slot_ff;
      valid_in        = valid_ff;
      occupancy_in    = occupancy_ff;
      access_clock_in = access_clock_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_value_in    = rsp_value_ff;
      scan_clear      = 1'b0;
      mem_re          = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = match_slot;
      mem_wdata.key   = key_ff;
      mem_wdata.value = match_entry.value;
      mem_wdata.count = bumped_count;
      mem_wdata.stamp = access_clock_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in      = req_tuser[0];
               key_in     = req_tdata[31:0];
               value_in   = req_tdata[63:32];
               rd_cnt_in  = '0;
               scan_clear = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one slot read a cycle; leave as the last slot is probed
            if (rd_cnt_ff < LAST_CNT) begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
               rd_slot_in = mem_raddr;
               rd_cnt_in  = CNT_W'(rd_cnt_ff + 1'b1);
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (op_ff == lfukv_pkg::OP_GET) begin
               // hold until the response register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  state_in      = ST_IDLE;
                  rsp_tvalid_in = 1'b1;
                  rsp_hit_in    = scan_flags.match_found;
                  rsp_value_in  = scan_flags.match_found ? match_entry.value :
                                  lfukv_pkg::MISS_VALUE;
                  if (scan_flags.match_found) begin
                     mem_we          = 1'b1;
                     access_clock_in = 32'(access_clock_ff + 32'd1);
                  end
               end
            end else begin
               state_in = ST_IDLE;
               if (cap_eff != 8'd0) begin
                  if (scan_flags.match_found) begin
                     // update in place and count one use
                     mem_we          = 1'b1;
                     mem_wdata.value = value_ff;
                     access_clock_in = 32'(access_clock_ff + 32'd1);
                  end else begin
                     // drop the victim if full, then insert
                     if (need_evict) begin
                        valid_in[victim_slot] = 1'b0;
                     end
                     valid_in[ins_slot] = 1'b1;
                     occupancy_in    = need_evict ? occupancy_ff :
                                       CNT_W'(occupancy_ff + 1'b1);
                     mem_we          = 1'b1;
                     mem_waddr       = ins_slot;
                     mem_wdata.value = value_ff;
                     mem_wdata.count = lfukv_pkg::COUNT_ONE;
                     access_clock_in = 32'(access_clock_ff + 32'd1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rd_pend_ff       <= 1'b0;
         valid_ff         <= '0;
         occupancy_ff     <= '0;
         access_clock_ff  <= '0;
         live_capacity_ff <= lfukv_pkg::LIVE_CAPACITY_RESET;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rd_pend_ff       <= rd_pend_in;
         valid_ff         <= valid_in;
         occupancy_ff     <= occupancy_in;
         access_clock_ff  <= access_clock_in;
         live_capacity_ff <= live_capacity_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rd_cnt_ff    <= rd_cnt_in;
      rd_slot_ff   <= rd_slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

   `LFUKV_ASSERT_IMPLY(a_occupancy_tracks_valid, clock, reset, 1'b1, ($countones(valid_ff) == int'(occupancy_ff)), "occupancy differs from valid slot count")

   `LFUKV_ASSERT_IMPLY(a_rsp_from_get_only, clock, reset, $rose(rsp_tvalid_ff), (($past(state_ff) == ST_UPDATE) && ($past(op_ff) == lfukv_pkg::OP_GET)), "response raised outside a get write-back")

   `LFUKV_ASSERT_IMPLY(a_full_has_victim, clock, reset, ((state_ff == ST_UPDATE) && !scan_flags.free_found), scan_flags.victim_found, "no free slot and no victim after sweep")

   `LFUKV_ASSERT_NEXT(a_accept_starts_sweep, clock, reset, req_fire, ((state_ff == ST_SCAN) && (rd_cnt_ff == '0)), "accepted word did not start a sweep")

endmodule

// File: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = 8;
   localparam int KEY_POOL    = 12;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 20;
   localparam int HOT_GETS    = 24;
   localparam int ADDR_W      = lfukv_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] CAPACITY_ADDR =
      ADDR_W'(4 * int'(lfukv_pkg::CSR_IDX_LIVE_CAPACITY));

   typedef struct {
      logic        op;
      logic [31:0] key;
      logic [31:0] value;
      bit          wait_drain;
   } cache_request_type;

   typedef struct {
      logic        hit;
      logic [31:0] value;
   } read_result_type;

   // DUT ports
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // [31:0] lookup_key, [63:32] store_value
   logic [0:0]  req_tuser   = '0;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] read_value
   logic [0:0]  rsp_tuser;          // [0] hit
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Stimulus and scoreboard
   cache_request_type pending_requests[$];
   read_result_type   expected_reads[$];
   logic [31:0]       key_pool[KEY_POOL];
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                fail_count    = 0;
   int                quiet_cycles  = 0;
   bit                req_fire      = 1'b0;

   // Shadow copy of the cache
   bit          slot_valid[ENTRIES] = '{default: 1'b0};
   logic [31:0] slot_key[ENTRIES];
   logic [31:0] slot_value[ENTRIES];
   logic [15:0] slot_count[ENTRIES];
   logic [31:0] slot_stamp[ENTRIES];
   logic [31:0] use_clock     = '0;
   int          occupancy     = 0;
   logic [3:0]  live_capacity = lfukv_pkg::LIVE_CAPACITY_RESET;

   always #4 clock = ~clock;

   lfu_key_value_cache_core #(.ENTRIES(ENTRIES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic int find_slot(logic [31:0] key);
      for (int s = 0; s < ENTRIES; s++) begin
         if (slot_valid[s] && slot_key[s] == key) return s;
      end
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int s = 0; s < ENTRIES; s++) begin
         if (!slot_valid[s]) return s;
      end
      return -1;
   endfunction

   // Count one use (saturating) and stamp it with the access clock
   function automatic void touch_slot(int s);
      if (slot_count[s] != lfukv_pkg::COUNT_MAX) slot_count[s]++;
      slot_stamp[s] = use_clock;
      use_clock++;
   endfunction

   // Drop the lowest-count entry, oldest first among equal counts
   function automatic void evict_lfu_slot();
      int          victim = -1;
      logic [15:0] best_count = '0;
      logic [31:0] best_age = '0;
      logic [31:0] age;
      for (int s = 0; s < ENTRIES; s++) begin
         if (!slot_valid[s]) continue;
         age = use_clock - slot_stamp[s];
         if (victim < 0 || slot_count[s] < best_count ||
             (slot_count[s] == best_count && age > best_age)) begin
            victim     = s;
            best_count = slot_count[s];
            best_age   = age;
         end
      end
      if (victim >= 0) begin
         slot_valid[victim] = 1'b0;
         if (occupancy > 0) occupancy--;
      end
   endfunction

   // Apply one request word to the shadow cache; gets yield a read result
   function automatic void cache_predict(input logic op, input logic [31:0] key,
                                         input logic [31:0] value,
                                         output bit has_read, output read_result_type rd);
      int cap;
      int s;
      int f;
      cap      = (int'(live_capacity) > ENTRIES) ? ENTRIES : int'(live_capacity);
      s        = find_slot(key);
      has_read = 1'b0;
      rd.hit   = 1'b0;
      rd.value = lfukv_pkg::MISS_VALUE;
      if (op == lfukv_pkg::OP_GET) begin
         has_read = 1'b1;
         if (s >= 0) begin
            touch_slot(s);
            rd.hit   = 1'b1;
            rd.value = slot_value[s];
         end
         return;
      end
      if (cap == 0) return;
      if (s >= 0) begin
         slot_value[s] = value;
         touch_slot(s);
         return;
      end
      if (occupancy >= cap) evict_lfu_slot();
      f = first_free_slot();
      if (f < 0) begin
         evict_lfu_slot();
         f = first_free_slot();
         if (f < 0) return;
      end
      slot_valid[f] = 1'b1;
      slot_key[f]   = key;
      slot_value[f] = value;
      slot_count[f] = lfukv_pkg::COUNT_ONE;
      slot_stamp[f] = use_clock;
      use_clock++;
      occupancy++;
   endfunction

   // Drive request words at the falling edge
   always @(negedge clock) begin : req_driver
      cache_request_type item;
      if (!req_tvalid || req_fire) begin
         if (!reset && pending_requests.size() != 0 &&
             !(pending_requests[0].wait_drain && expected_reads.size() != 0) &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {item.value, item.key};
            req_tuser  <= item.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Throttle the result side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Check result words and predict from accepted request words
   always @(posedge clock) begin : monitor
      bit              has_read;
      read_result_type rd;
      read_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reads.size() == 0) begin
               $error("result word with no get waiting: hit %0d read_value %h",
                      rsp_tuser[0], rsp_tdata);
               fail_count++;
            end else begin
               want = expected_reads.pop_front();
               if (rsp_tuser[0] !== want.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tdata !== want.value) begin
                  $error("read_value mismatch: expected %h, actual %h", want.value, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cache_predict(req_tuser[0], req_tdata[31:0], req_tdata[63:32], has_read, rd);
            if (has_read) expected_reads.push_back(rd);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_request(input logic op, input logic [31:0] key,
                              input logic [31:0] value, input bit wait_drain = 1'b0);
      cache_request_type item;
      item.op         = op;
      item.key        = key;
      item.value      = value;
      item.wait_drain = wait_drain;
      pending_requests.push_back(item);
   endtask

   // Mostly keys from a shared pool, skewed so some keys get used often
   task automatic add_random(input int count);
      logic [31:0] key;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(0, $urandom_range(0, KEY_POOL - 1))];
         add_request($urandom_range(0, 1) ? lfukv_pkg::OP_PUT : lfukv_pkg::OP_GET, key,
                     $urandom, i == count / 2);
      end
   endtask

   // Hold until every word is accepted, every read has come and the last put is done
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_reads.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [3:0] cap);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= {28'd0, cap};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      live_capacity = cap;
   endtask

   initial begin : stimulus
      logic [31:0] hot_key;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender rarely idle, receiver mostly stalled
      send_idle_pct = 8;
      recv_idle_pct = 73;

      // Directed: empty miss, key and value extremes, update, eviction order
      add_request(lfukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      add_request(lfukv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      add_request(lfukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      add_request(lfukv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      add_request(lfukv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      add_request(lfukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      add_request(lfukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_request(lfukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      add_request(lfukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      add_request(lfukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      add_request(lfukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      for (int k = 1; k <= 4; k++) begin
         add_request(lfukv_pkg::OP_PUT, 32'(k), 32'(32'hA5A5_0000 + 32'(k)));
      end
      // Cache full: single-use entries go out oldest first
      add_request(lfukv_pkg::OP_PUT, 32'd5, 32'h5555_5555);
      add_request(lfukv_pkg::OP_GET, 32'd1, 32'h0000_0000);
      add_request(lfukv_pkg::OP_GET, 32'd2, 32'h0000_0000);
      add_request(lfukv_pkg::OP_PUT, 32'd6, 32'h6666_6666);
      add_request(lfukv_pkg::OP_GET, 32'd3, 32'h0000_0000);
      add_request(lfukv_pkg::OP_GET, 32'd6, 32'h0000_0000);
      add_random(250);
      wait_idle();
      write_capacity(4'd3);
      add_random(150);
      wait_idle();
      // Capacity zero: puts do nothing, gets still hit
      write_capacity(4'd0);
      add_random(60);
      wait_idle();

      // Sender mostly idle, receiver rarely stalled
      send_idle_pct = 73;
      recv_idle_pct = 8;
      write_capacity(4'd15);
      add_random(250);
      wait_idle();
      write_capacity(4'd1);
      add_random(120);
      wait_idle();
      write_capacity(4'd8);
      add_random(100);
      wait_idle();
      // Lower the capacity below the occupancy
      write_capacity(4'd2);
      add_random(100);
      wait_idle();

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_capacity(4'd8);
      // Build up one key's count, then push new keys past it
      hot_key = $urandom;
      add_request(lfukv_pkg::OP_PUT, hot_key, $urandom);
      for (int i = 0; i < HOT_GETS; i++) add_request(lfukv_pkg::OP_GET, hot_key, $urandom);
      for (int i = 0; i < ENTRIES; i++) add_request(lfukv_pkg::OP_PUT, $urandom, $urandom);
      add_request(lfukv_pkg::OP_GET, hot_key, $urandom);
      add_random(250);
      wait_idle();
      write_capacity(4'd5);
      add_random(120);
      wait_idle();

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/lfukv_pkg.sv
hdl/lfukv_scan.sv
hdl/lfu_key_value_cache_core.sv
sim/testbench.sv
